### sv/irpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_pkg
// Shared types and constants for the remote-control pulse decoder: phase
// codes, timing windows and frame checks.
// ----------------------------------------------------------------------------
package irpd_pkg;

  localparam int unsigned PhaseW = 3;
  localparam int unsigned CountW = 6;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned FrameW = 32;
  localparam int unsigned ByteW  = 8;

  // Phase codes
  localparam logic [PhaseW-1:0] PH_IDLE      = 3'd0;
  localparam logic [PhaseW-1:0] PH_HDR_PULSE = 3'd1;
  localparam logic [PhaseW-1:0] PH_HDR_SPACE = 3'd2;
  localparam logic [PhaseW-1:0] PH_BIT_PULSE = 3'd3;
  localparam logic [PhaseW-1:0] PH_BIT_SPACE = 3'd4;

  localparam logic [CountW-1:0] FRAME_BITS = 6'd32;

  localparam logic [ByteW-1:0] CUSTOM_RESET = 8'ha8;

  // Timing windows in microseconds, both bounds inclusive
  localparam logic [TimeW-1:0] HDR_PULSE_MIN = 16'd5800;
  localparam logic [TimeW-1:0] HDR_PULSE_MAX = 16'd11199;
  localparam logic [TimeW-1:0] HDR_SPACE_MIN = 16'd3400;
  localparam logic [TimeW-1:0] HDR_SPACE_MAX = 16'd6199;
  localparam logic [TimeW-1:0] BIT_PULSE_MIN = 16'd380;
  localparam logic [TimeW-1:0] BIT_PULSE_MAX = 16'd1069;
  localparam logic [TimeW-1:0] ONE_SPACE_MIN = 16'd1260;
  localparam logic [TimeW-1:0] ONE_SPACE_MAX = 16'd4719;
  localparam logic [TimeW-1:0] ZERO_SPACE_MIN = 16'd300;
  localparam logic [TimeW-1:0] ZERO_SPACE_MAX = 16'd1064;

  typedef struct packed {
    logic              last_level;
    logic [PhaseW-1:0] phase;
    logic [FrameW-1:0] frame_shift;
    logic [CountW-1:0] bit_count;
  } dec_state_t;

  typedef struct packed {
    logic             code_valid;
    logic [ByteW-1:0] code_byte;
  } dec_result_t;

endpackage

### sv/irpd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_edge_if / irpd_code_if
// Valid/ready channels for line edges in and decoded codes out.
// ----------------------------------------------------------------------------
interface irpd_edge_if;
  logic                            valid;
  logic                            ready;
  logic                            level;
  logic [irpd_pkg::TimeW-1:0]      elapsed_us;

  modport source (output valid, output level, output elapsed_us, input ready);
  modport sink   (input valid, input level, input elapsed_us, output ready);
endinterface

interface irpd_code_if;
  logic                            valid;
  logic                            ready;
  logic                            code_valid;
  logic [irpd_pkg::ByteW-1:0]      code_byte;

  modport source (output valid, output code_valid, output code_byte, input ready);
  modport sink   (input valid, input code_valid, input code_byte, output ready);
endinterface

### sv/irpd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irpd_step
// Next-state and result logic for one line edge: window checks, bit
// gathering and the frame check on the last bit.
// ----------------------------------------------------------------------------
module irpd_step (
  input  irpd_pkg::dec_state_t             cur,
  input  logic                             level,
  input  logic [irpd_pkg::TimeW-1:0]       elapsed_us,
  input  logic [irpd_pkg::ByteW-1:0]       expected_custom,
  output irpd_pkg::dec_state_t             nxt,
  output irpd_pkg::dec_result_t            res
);

  logic                              in_hdr_pulse;
  logic                              in_hdr_space;
  logic                              in_bit_pulse;
  logic                              is_one;
  logic                              is_zero;
  logic [irpd_pkg::CountW-1:0]       cnt_inc;
  logic [irpd_pkg::FrameW-1:0]       shift_new;
  logic                              frame_ok;

  assign in_hdr_pulse = elapsed_us inside {[irpd_pkg::HDR_PULSE_MIN:irpd_pkg::HDR_PULSE_MAX]};
  assign in_hdr_space = elapsed_us inside {[irpd_pkg::HDR_SPACE_MIN:irpd_pkg::HDR_SPACE_MAX]};
  assign in_bit_pulse = elapsed_us inside {[irpd_pkg::BIT_PULSE_MIN:irpd_pkg::BIT_PULSE_MAX]};
  assign is_one       = elapsed_us inside {[irpd_pkg::ONE_SPACE_MIN:irpd_pkg::ONE_SPACE_MAX]};
  assign is_zero      = elapsed_us inside {[irpd_pkg::ZERO_SPACE_MIN:irpd_pkg::ZERO_SPACE_MAX]};

  assign cnt_inc   = cur.bit_count + 6'd1;
  // Bits land LSB first
  assign shift_new = is_one ? (cur.frame_shift | (32'd1 << cur.bit_count[4:0]))
                            : cur.frame_shift;

  assign frame_ok = (shift_new[7:0] == ~shift_new[15:8]) &&
                    (shift_new[7:0] == expected_custom) &&
                    (shift_new[23:16] == ~shift_new[31:24]);

  always_comb begin
    nxt            = cur;
    res.code_valid = 1'b0;
    res.code_byte  = '0;
    if (level != cur.last_level) begin
      nxt.last_level = level;
      case (cur.phase)
        irpd_pkg::PH_HDR_PULSE: begin
          nxt.phase = in_hdr_pulse ? irpd_pkg::PH_HDR_SPACE : irpd_pkg::PH_IDLE;
        end
        irpd_pkg::PH_HDR_SPACE: begin
          nxt.phase = in_hdr_space ? irpd_pkg::PH_BIT_PULSE : irpd_pkg::PH_IDLE;
        end
        irpd_pkg::PH_BIT_PULSE: begin
          nxt.phase = in_bit_pulse ? irpd_pkg::PH_BIT_SPACE : irpd_pkg::PH_IDLE;
        end
        irpd_pkg::PH_BIT_SPACE: begin
          if (is_one || is_zero) begin
            nxt.frame_shift = shift_new;
            nxt.bit_count   = cnt_inc;
            if (cnt_inc == irpd_pkg::FRAME_BITS) begin
              nxt.phase = irpd_pkg::PH_IDLE;
              if (frame_ok) begin
                res.code_valid = 1'b1;
                res.code_byte  = shift_new[23:16];
              end
            end else begin
              nxt.phase = irpd_pkg::PH_BIT_PULSE;
            end
          end else begin
            nxt.phase = irpd_pkg::PH_IDLE;
          end
        end
        default: begin
          // Idle and the unused codes: a rising edge opens a frame
          nxt.phase = irpd_pkg::PH_IDLE;
          if (level) begin
            nxt.frame_shift = '0;
            nxt.bit_count   = '0;
            nxt.phase       = irpd_pkg::PH_HDR_PULSE;
          end
        end
      endcase
    end
  end

endmodule

### sv/ir_remote_pulse_decoder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ir_remote_pulse_decoder_unit
// Decodes a pulse-width coded remote-control line from a stream of edge
// transfers (new level, microseconds since the previous edge) into command
// bytes. Every edge gives exactly one result transfer: code_valid is 1 with
// the command byte when that edge completed a 32-bit frame whose custom byte
// matches cfg and whose check bytes are the complements, otherwise both
// fields are 0. The block takes one edge per clock while the result side
// accepts; a taken edge passes through the input register and then the
// result register; the decode state updates as the edge moves into the
// result register. Backpressure on the result side stalls both stages.
// The expected custom byte resets to 0xa8. The user must write it through
// cfg_we/cfg_wdata only while no edge is in flight; it is not enforced.
// ----------------------------------------------------------------------------
module ir_remote_pulse_decoder_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  irpd_edge_if.sink                    in_ch,
  irpd_code_if.source                  out_ch,
  input  logic                         cfg_we,
  input  logic [irpd_pkg::ByteW-1:0]   cfg_wdata
);

  logic [irpd_pkg::ByteW-1:0]   expected_custom_r;

  logic                         s1_valid_r;
  logic                         s1_level_r;
  logic [irpd_pkg::TimeW-1:0]   s1_elapsed_r;

  irpd_pkg::dec_state_t         st_r;
  irpd_pkg::dec_state_t         st_nxt;
  irpd_pkg::dec_result_t        res_nxt;

  logic                         out_valid_r;
  irpd_pkg::dec_result_t        out_res_r;

  logic                         s1_adv;
  logic                         in_xfer;

  assign s1_adv       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || s1_adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  irpd_step u_step (
    .cur             (st_r),
    .level           (s1_level_r),
    .elapsed_us      (s1_elapsed_r),
    .expected_custom (expected_custom_r),
    .nxt             (st_nxt),
    .res             (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expected_custom_r <= irpd_pkg::CUSTOM_RESET;
    end else if (cfg_we) begin
      expected_custom_r <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_level_r   <= in_ch.level;
      s1_elapsed_r <= in_ch.elapsed_us;
    end
  end

  // Decode state advances only as an edge moves into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.last_level  <= 1'b0;
      st_r.phase       <= irpd_pkg::PH_IDLE;
      st_r.frame_shift <= '0;
      st_r.bit_count   <= '0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.code_valid = out_res_r.code_valid;
  assign out_ch.code_byte  = out_res_r.code_byte;

  // A completed frame always leaves the decoder idle
  a_idle_after_code: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res_nxt.code_valid) |=> (st_r.phase == irpd_pkg::PH_IDLE))
    else $error("decoder not idle after a completed frame");

  // The bit counter never runs past one frame
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.bit_count <= irpd_pkg::FRAME_BITS))
    else $error("bit counter beyond frame length");

  // An empty result register never holds back the input side
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ch.ready)
    else $error("input stalled with empty result register");

  // A result that is not a code carries a zero byte
  a_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.code_valid) |-> (out_res_r.code_byte == '0))
    else $error("non-code result with non-zero byte");

endmodule
